### hw/rtl/u8rf_pkg.sv
// ----------------------------------------------------------------------------
// u8rf_pkg
// Shared types and constants for the UART 8N1 unit with its receive FIFO.
// ----------------------------------------------------------------------------
`default_nettype none

package u8rf_pkg;

   localparam int unsigned FIFO_DEPTH      = 16;
   localparam int unsigned RSP_QUEUE_DEPTH = 4;

   localparam int unsigned CSR_INDEX_WIDTH = 2;
   localparam int unsigned CSR_DATA_WIDTH  = 16;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TX_BIT_TICKS = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_RX_BIT_TICKS = 2'd1;

   localparam logic [CSR_DATA_WIDTH-1:0] TX_BIT_TICKS_RESET = 16'd92;
   localparam logic [CSR_DATA_WIDTH-1:0] RX_BIT_TICKS_RESET = 16'd94;

   // transmit frame slots: start bit, eight data bits, stop bit
   localparam logic [3:0] TX_STOP_INDEX = 4'd9;
   localparam logic [3:0] TX_LAST_DATA  = 4'd8;
   localparam logic [2:0] RX_LAST_DATA  = 3'd7;

   typedef enum logic [1:0] {
      RX_IDLE,
      RX_DATA,
      RX_STOP,
      RX_DROP
   } rx_phase_type;

   typedef struct packed {
      logic line;
      logic busy;
   } tx_status_type;

   typedef struct packed {
      logic       got;
      logic       led;
      logic [7:0] head;
   } rx_status_type;

endpackage

`default_nettype wire

### hw/rtl/u8rf_tx.sv
// ----------------------------------------------------------------------------
// u8rf_tx
// 8N1 transmitter, one tick per accepted request, LSB first.
// ----------------------------------------------------------------------------
`default_nettype none

module u8rf_tx (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     tick,
   input  wire logic [15:0]              bit_ticks,
   input  wire logic                     start,
   input  wire logic [7:0]               data,
   output u8rf_pkg::tx_status_type       status
);

   logic        active_ff, active_in;
   logic [7:0]  shift_ff, shift_in;
   logic [3:0]  index_ff, index_in;
   logic [15:0] timer_ff, timer_in;
   logic        line_ff, line_in;
   logic        busy_ff;

   logic [15:0] period;
   logic        run_active;
   logic [7:0]  run_shift;
   logic [3:0]  run_index;
   logic [15:0] run_timer;
   logic [15:0] timer_dec;
   logic [2:0]  bit_sel;

   always_comb begin
      period     = (bit_ticks == 16'd0) ? 16'd1 : bit_ticks;
      run_active = active_ff | start;
      run_shift  = active_ff ? shift_ff : data;
      run_index  = active_ff ? index_ff : 4'd0;
      run_timer  = active_ff ? timer_ff : period;
      bit_sel    = 3'(run_index - 4'd1);
      timer_dec  = (run_timer != 16'd0) ? run_timer - 16'd1 : 16'd0;

      if (!run_active) begin
         line_in = 1'b1;
      end else if (run_index == 4'd0) begin
         line_in = 1'b0;
      end else if (run_index <= u8rf_pkg::TX_LAST_DATA) begin
         line_in = run_shift[bit_sel];
      end else begin
         line_in = 1'b1;
      end

      active_in = run_active;
      shift_in  = run_shift;
      index_in  = run_index;
      timer_in  = run_timer;
      if (run_active) begin
         if (timer_dec == 16'd0) begin
            if (run_index == u8rf_pkg::TX_STOP_INDEX) begin
               // stop bit done: drop back to idle
               active_in = 1'b0;
               index_in  = 4'd0;
               timer_in  = 16'd0;
            end else begin
               index_in = run_index + 4'd1;
               timer_in = period;
            end
         end else begin
            timer_in = timer_dec;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         shift_ff  <= 8'd0;
         index_ff  <= 4'd0;
         timer_ff  <= 16'd0;
         line_ff   <= 1'b1;
         busy_ff   <= 1'b0;
      end else if (tick) begin
         active_ff <= active_in;
         shift_ff  <= shift_in;
         index_ff  <= index_in;
         timer_ff  <= timer_in;
         line_ff   <= line_in;
         busy_ff   <= run_active;
      end
   end

   assign status.line = line_ff;
   assign status.busy = busy_ff;

endmodule

`default_nettype wire

### hw/rtl/u8rf_rx.sv
// ----------------------------------------------------------------------------
// u8rf_rx
// 8N1 receiver with a circular receive FIFO and a registered head read.
// ----------------------------------------------------------------------------
`default_nettype none

module u8rf_rx #(
   parameter int unsigned FifoDepth  = u8rf_pkg::FIFO_DEPTH,
   parameter int unsigned CountWidth = $clog2(FifoDepth + 1)
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     tick,
   input  wire logic [15:0]              bit_ticks,
   input  wire logic                     rx_line,
   input  wire logic                     pop,
   input  wire logic                     clear,
   output u8rf_pkg::rx_status_type       status,
   output logic [CountWidth-1:0]         count
);

   localparam int unsigned AddrWidth = (FifoDepth > 1) ? $clog2(FifoDepth) : 1;
   localparam logic [AddrWidth-1:0] LastAddr = AddrWidth'(FifoDepth - 1);
   localparam logic [CountWidth-1:0] FullCount = CountWidth'(FifoDepth);

   u8rf_pkg::rx_phase_type phase_ff, phase_in;
   logic [19:0]           timer_ff, timer_in;
   logic [2:0]            index_ff, index_in;
   logic [7:0]            shift_ff, shift_in;
   logic                  prev_ff;
   logic [CountWidth-1:0] fill_ff, fill_in;
   logic [AddrWidth-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [AddrWidth-1:0]  wr_ptr_ff, wr_ptr_in;
   logic                  led_ff;
   logic                  got_ff;
   logic [7:0]            head_ff;
   logic [7:0]            mem [FifoDepth];

   logic [19:0]           period;
   logic [19:0]           start_wait;
   logic [20:0]           drop_span;
   logic [19:0]           drop_wait;
   logic [19:0]           timer_dec;
   logic                  do_pop;
   logic [CountWidth-1:0] fill_pop;
   logic                  fifo_full;
   logic                  fall;
   logic                  sample;
   logic                  store;
   logic [7:0]            store_byte;
   logic [AddrWidth-1:0]  rd_inc;
   logic [AddrWidth-1:0]  wr_inc;

   always_comb begin
      period     = (bit_ticks < 16'd2) ? 20'd2 : 20'(bit_ticks);
      start_wait = (period >> 1) + period;
      drop_span  = (21'(period) << 4) + (21'(period) << 1) + 21'(period);
      drop_wait  = 20'(drop_span >> 1);
      timer_dec  = (timer_ff != 20'd0) ? timer_ff - 20'd1 : 20'd0;
      do_pop     = pop && (fill_ff != '0);
      fill_pop   = fill_ff - CountWidth'(do_pop);
      fifo_full  = fill_pop >= FullCount;
      fall       = prev_ff && !rx_line;
      sample     = (phase_ff == u8rf_pkg::RX_DATA) && (timer_dec == 20'd0);
      store_byte = {rx_line, shift_ff[7:1]};
      store      = sample && (index_ff == u8rf_pkg::RX_LAST_DATA) && !fifo_full;
      rd_inc     = (rd_ptr_ff == LastAddr) ? '0 : rd_ptr_ff + 1'b1;
      wr_inc     = (wr_ptr_ff == LastAddr) ? '0 : wr_ptr_ff + 1'b1;
   end

   // next phase
   always_comb begin
      phase_in = phase_ff;
      unique case (phase_ff)
         u8rf_pkg::RX_IDLE: begin
            if (fall) begin
               phase_in = fifo_full ? u8rf_pkg::RX_DROP : u8rf_pkg::RX_DATA;
            end
         end
         u8rf_pkg::RX_DATA: begin
            if (sample && (index_ff == u8rf_pkg::RX_LAST_DATA)) begin
               phase_in = u8rf_pkg::RX_STOP;
            end
         end
         u8rf_pkg::RX_STOP, u8rf_pkg::RX_DROP: begin
            if (timer_dec == 20'd0) begin
               phase_in = u8rf_pkg::RX_IDLE;
            end
         end
         default: phase_in = u8rf_pkg::RX_IDLE;
      endcase
   end

   // datapath and FIFO pointers
   always_comb begin
      timer_in = timer_ff;
      index_in = index_ff;
      shift_in = shift_ff;
      unique case (phase_ff)
         u8rf_pkg::RX_IDLE: begin
            if (fall) begin
               if (fifo_full) begin
                  timer_in = drop_wait;
               end else begin
                  timer_in = start_wait;
                  index_in = 3'd0;
                  shift_in = 8'd0;
               end
            end
         end
         u8rf_pkg::RX_DATA: begin
            if (sample) begin
               shift_in = store_byte;
               index_in = index_ff + 3'd1;
               timer_in = period;
            end else begin
               timer_in = timer_dec;
            end
         end
         u8rf_pkg::RX_STOP, u8rf_pkg::RX_DROP: begin
            timer_in = timer_dec;
         end
         default: timer_in = timer_ff;
      endcase

      if (clear) begin
         fill_in   = '0;
         rd_ptr_in = '0;
         wr_ptr_in = '0;
      end else begin
         fill_in   = fill_pop + CountWidth'(store);
         rd_ptr_in = do_pop ? rd_inc : rd_ptr_ff;
         wr_ptr_in = store ? wr_inc : wr_ptr_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= u8rf_pkg::RX_IDLE;
         timer_ff  <= 20'd0;
         index_ff  <= 3'd0;
         shift_ff  <= 8'd0;
         prev_ff   <= 1'b1;
         fill_ff   <= '0;
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         led_ff    <= 1'b0;
         got_ff    <= 1'b0;
      end else if (tick) begin
         phase_ff  <= phase_in;
         timer_ff  <= timer_in;
         index_ff  <= index_in;
         shift_ff  <= shift_in;
         prev_ff   <= rx_line;
         fill_ff   <= fill_in;
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         led_ff    <= led_ff ^ store;
         got_ff    <= store;
      end
   end

   // head read: bypass the byte being written into an empty FIFO
   always_ff @(posedge clock) begin
      if (tick && store) begin
         mem[wr_ptr_ff] <= store_byte;
      end
      if (tick) begin
         head_ff <= (store && (wr_ptr_ff == rd_ptr_in)) ? store_byte : mem[rd_ptr_in];
      end
   end

   assign status.got  = got_ff;
   assign status.led  = led_ff;
   assign status.head = (fill_ff == '0) ? 8'd0 : head_ff;
   assign count       = fill_ff;

endmodule

`default_nettype wire

### hw/rtl/u8rf_rsp_queue.sv
// ----------------------------------------------------------------------------
// u8rf_rsp_queue
// Small result queue between the tick engines and the response port.
// ----------------------------------------------------------------------------
`default_nettype none

module u8rf_rsp_queue #(
   parameter int unsigned Width  = 1,
   parameter int unsigned Depth  = u8rf_pkg::RSP_QUEUE_DEPTH,
   parameter int unsigned CountWidth = $clog2(Depth + 1)
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   input  wire logic [Width-1:0]      push_data,
   input  wire logic                  pop,
   output logic [Width-1:0]           pop_data,
   output logic                       empty,
   output logic [CountWidth-1:0]      count
);

   localparam int unsigned AddrWidth = (Depth > 1) ? $clog2(Depth) : 1;
   localparam logic [AddrWidth-1:0] LastAddr = AddrWidth'(Depth - 1);

   logic [Width-1:0]      entries_ff [Depth];
   logic [AddrWidth-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [AddrWidth-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [CountWidth-1:0] count_ff, count_in;
   logic                  do_pop;

   always_comb begin
      do_pop    = pop && (count_ff != '0);
      rd_ptr_in = rd_ptr_ff;
      wr_ptr_in = wr_ptr_ff;
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LastAddr) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LastAddr) ? '0 : wr_ptr_ff + 1'b1;
      end
      count_in = count_ff + CountWidth'(push) - CountWidth'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data = entries_ff[rd_ptr_ff];
   assign empty    = (count_ff == '0);
   assign count    = count_ff;

endmodule

`default_nettype wire

### hw/rtl/uart_8n1_with_rx_fifo_unit.sv
// ----------------------------------------------------------------------------
// uart_8n1_with_rx_fifo_unit
// Full-duplex 8N1 UART driven one tick per request, with a receive FIFO.
// ----------------------------------------------------------------------------
// Each request is one line tick and yields exactly one response, in order.
// A new request is taken every clock cycle as long as req_full is low. The
// transmitter and receiver update their state in the cycle a request is
// taken; the response is formed from registered state in the next cycle
// (the head byte comes from a registered FIFO read) and then waits in a
// four-entry result queue. req_full rises when that queue plus the one
// response in flight would fill it. A response reaches the rsp_ ports once
// the s1 stage has pushed it into the queue and older responses have gone,
// and a steady stream runs at one per cycle when responses are popped as fast.
// Bit times are set through the csr_ port
// (index 0 transmit, index 1 receive) and must only change while idle. The
// receive FIFO needs no clearing after reset: its contents are masked by the
// fill count, and the head byte reads zero when the FIFO is empty.
`default_nettype none

module uart_8n1_with_rx_fifo_unit #(
   parameter int unsigned FIFO_DEPTH = u8rf_pkg::FIFO_DEPTH,
   parameter int unsigned CountWidth = $clog2(FIFO_DEPTH + 1)
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,

   input  wire logic                                  req_push,
   output logic                                       req_full,
   input  wire logic                                  req_rx_line,
   input  wire logic                                  req_tx_start,
   input  wire logic [7:0]                            req_tx_data,
   input  wire logic                                  req_pop_req,
   input  wire logic                                  req_clear,

   output logic                                       rsp_empty,
   input  wire logic                                  rsp_pop,
   output logic                                       rsp_tx_line,
   output logic                                       rsp_tx_busy,
   output logic [7:0]                                 rsp_head_byte,
   output logic [CountWidth-1:0]                      rsp_fifo_count,
   output logic                                       rsp_byte_received,
   output logic                                       rsp_activity_led,

   input  wire logic                                  csr_valid,
   output logic                                       csr_ready,
   input  wire logic [u8rf_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  wire logic [u8rf_pkg::CSR_DATA_WIDTH-1:0]   csr_wdata
);

   localparam int unsigned QDepth      = u8rf_pkg::RSP_QUEUE_DEPTH;
   localparam int unsigned QCountWidth = $clog2(QDepth + 1);
   localparam int unsigned RspWidth    = 1 + 1 + 8 + CountWidth + 1 + 1;

   logic [15:0]              tx_bit_ticks_ff;
   logic [15:0]              rx_bit_ticks_ff;
   logic                     s1_valid_ff;
   logic                     tick;
   logic [QCountWidth-1:0]   q_count;
   logic [QCountWidth:0]     q_pending;
   u8rf_pkg::tx_status_type  tx_status;
   u8rf_pkg::rx_status_type  rx_status;
   logic [CountWidth-1:0]    rx_count;
   logic [RspWidth-1:0]      rsp_word;
   logic [RspWidth-1:0]      rsp_head_word;

   assign q_pending = (QCountWidth + 1)'(q_count) + (QCountWidth + 1)'(s1_valid_ff);
   assign req_full  = q_pending >= (QCountWidth + 1)'(QDepth);
   assign tick      = req_push && !req_full;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         tx_bit_ticks_ff <= u8rf_pkg::TX_BIT_TICKS_RESET;
         rx_bit_ticks_ff <= u8rf_pkg::RX_BIT_TICKS_RESET;
         s1_valid_ff     <= 1'b0;
      end else begin
         s1_valid_ff <= tick;
         if (csr_valid) begin
            unique case (csr_index)
               u8rf_pkg::CSR_TX_BIT_TICKS: tx_bit_ticks_ff <= csr_wdata;
               u8rf_pkg::CSR_RX_BIT_TICKS: rx_bit_ticks_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   u8rf_tx u_tx (
      .clock     (clock),
      .reset     (reset),
      .tick      (tick),
      .bit_ticks (tx_bit_ticks_ff),
      .start     (req_tx_start),
      .data      (req_tx_data),
      .status    (tx_status)
   );

   u8rf_rx #(
      .FifoDepth  (FIFO_DEPTH),
      .CountWidth (CountWidth)
   ) u_rx (
      .clock     (clock),
      .reset     (reset),
      .tick      (tick),
      .bit_ticks (rx_bit_ticks_ff),
      .rx_line   (req_rx_line),
      .pop       (req_pop_req),
      .clear     (req_clear),
      .status    (rx_status),
      .count     (rx_count)
   );

   assign rsp_word = {tx_status.line, tx_status.busy, rx_status.head, rx_count,
                      rx_status.got, rx_status.led};

   u8rf_rsp_queue #(
      .Width      (RspWidth),
      .Depth      (QDepth),
      .CountWidth (QCountWidth)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (s1_valid_ff),
      .push_data (rsp_word),
      .pop       (rsp_pop),
      .pop_data  (rsp_head_word),
      .empty     (rsp_empty),
      .count     (q_count)
   );

   assign {rsp_tx_line, rsp_tx_busy, rsp_head_byte, rsp_fifo_count,
           rsp_byte_received, rsp_activity_led} = rsp_head_word;

`ifndef SYNTHESIS
   a_queue_room: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |-> (q_count < QCountWidth'(QDepth)))
      else $error("result queue overflow");

   a_tick_to_stage: assert property (@(posedge clock) disable iff (reset)
      (req_push && !req_full) |=> s1_valid_ff)
      else $error("accepted request produced no response");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_fifo_count <= CountWidth'(FIFO_DEPTH)))
      else $error("fifo count above depth");

   a_empty_head_zero: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && (rsp_fifo_count == '0)) |-> (rsp_head_byte == 8'd0))
      else $error("head byte nonzero with empty fifo");
`endif

endmodule

`default_nettype wire

### bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the UART 8N1 unit with its receive FIFO.
// ----------------------------------------------------------------------------
// Every request is one line tick. A line model in the bench predicts the
// status of each tick and queues it; every popped response is compared
// field by field against the oldest queued status. Receive traffic is mostly
// well-formed frames at the programmed rate, mixed with noise and cut-off
// frames. Bit rates are reprogrammed between phases while the line is quiet.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned CW          = $clog2(u8rf_pkg::FIFO_DEPTH + 1);
   localparam int unsigned CYCLE_LIMIT = 400000;

   typedef struct packed {
      logic       rx_line;
      logic       tx_start;
      logic [7:0] tx_data;
      logic       pop_req;
      logic       clear;
   } tick_type;

   typedef struct packed {
      logic          line;
      logic          busy;
      logic [7:0]    head;
      logic [CW-1:0] count;
      logic          got;
      logic          led;
   } status_type;

   logic                                 clock;
   logic                                 reset        = 1'b1;
   logic                                 req_push     = 1'b0;
   logic                                 req_full;
   logic                                 req_rx_line  = 1'b1;
   logic                                 req_tx_start = 1'b0;
   logic [7:0]                           req_tx_data  = 8'h00;
   logic                                 req_pop_req  = 1'b0;
   logic                                 req_clear    = 1'b0;
   logic                                 rsp_empty;
   logic                                 rsp_pop      = 1'b0;
   logic                                 rsp_tx_line;
   logic                                 rsp_tx_busy;
   logic [7:0]                           rsp_head_byte;
   logic [CW-1:0]                        rsp_fifo_count;
   logic                                 rsp_byte_received;
   logic                                 rsp_activity_led;
   logic                                 csr_valid    = 1'b0;
   logic                                 csr_ready;
   logic [u8rf_pkg::CSR_INDEX_WIDTH-1:0] csr_index    = u8rf_pkg::CSR_TX_BIT_TICKS;
   logic [u8rf_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata    = '0;

   uart_8n1_with_rx_fifo_unit dut (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_rx_line       (req_rx_line),
      .req_tx_start      (req_tx_start),
      .req_tx_data       (req_tx_data),
      .req_pop_req       (req_pop_req),
      .req_clear         (req_clear),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_tx_line       (rsp_tx_line),
      .rsp_tx_busy       (rsp_tx_busy),
      .rsp_head_byte     (rsp_head_byte),
      .rsp_fifo_count    (rsp_fifo_count),
      .rsp_byte_received (rsp_byte_received),
      .rsp_activity_led  (rsp_activity_led),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   // line model state
   logic [15:0]            tx_cfg, rx_cfg;
   logic                   tx_on;
   logic [3:0]             tx_slot;
   logic [7:0]             tx_byte;
   int unsigned            tx_left;
   u8rf_pkg::rx_phase_type rx_ph;
   int unsigned            rx_left;
   logic [2:0]             rx_bits;
   logic [7:0]             rx_sr;
   logic                   rx_prev;
   logic [7:0]             rx_fifo [u8rf_pkg::FIFO_DEPTH];
   int unsigned            rx_fill;
   logic                   led_q;

   status_type  status_due [$];
   logic        rx_levels [$];
   int unsigned mismatches = 0;
   int unsigned cycles     = 0;
   int unsigned pop_hold   = 0;
   bit          gaps_on    = 1'b1;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic int unsigned tx_rate();
      return (tx_cfg == 16'd0) ? 32'd1 : 32'(tx_cfg);
   endfunction

   function automatic int unsigned rx_rate();
      return (rx_cfg < 16'd2) ? 32'd2 : 32'(rx_cfg);
   endfunction

   // Advance the line model by one tick and return the status it reports.
   function automatic status_type uart_tick(input tick_type t);
      status_type  s;
      int unsigned p;
      s      = '0;
      s.line = 1'b1;

      if (!tx_on && t.tx_start) begin
         tx_on   = 1'b1;
         tx_byte = t.tx_data;
         tx_slot = '0;
         tx_left = tx_rate();
      end
      if (tx_on) begin
         s.busy = 1'b1;
         if (tx_slot == 4'd0)
            s.line = 1'b0;
         else if (tx_slot <= u8rf_pkg::TX_LAST_DATA)
            s.line = tx_byte[3'(tx_slot - 4'd1)];
         if (tx_left > 0)
            tx_left--;
         if (tx_left == 0) begin
            if (tx_slot == u8rf_pkg::TX_STOP_INDEX) begin
               tx_on   = 1'b0;
               tx_slot = '0;
            end else begin
               tx_slot++;
               tx_left = tx_rate();
            end
         end
      end

      // pop shifts the whole store down, zero filling the top
      if (t.pop_req && rx_fill > 0) begin
         for (int i = 0; i < u8rf_pkg::FIFO_DEPTH - 1; i++)
            rx_fifo[i] = rx_fifo[i + 1];
         rx_fifo[u8rf_pkg::FIFO_DEPTH - 1] = 8'h00;
         rx_fill--;
      end

      p = rx_rate();
      if (rx_ph == u8rf_pkg::RX_IDLE) begin
         if (rx_prev && !t.rx_line) begin
            if (rx_fill >= u8rf_pkg::FIFO_DEPTH) begin
               rx_ph   = u8rf_pkg::RX_DROP;
               rx_left = (19 * p) / 2;
            end else begin
               rx_ph   = u8rf_pkg::RX_DATA;
               rx_left = p / 2 + p;
               rx_bits = '0;
               rx_sr   = 8'h00;
            end
         end
      end else begin
         if (rx_left > 0)
            rx_left--;
         if (rx_left == 0) begin
            if (rx_ph == u8rf_pkg::RX_DATA) begin
               rx_sr   = {t.rx_line, rx_sr[7:1]};
               rx_left = p;
               if (rx_bits == u8rf_pkg::RX_LAST_DATA) begin
                  rx_bits = '0;
                  rx_ph   = u8rf_pkg::RX_STOP;
                  if (rx_fill < u8rf_pkg::FIFO_DEPTH) begin
                     rx_fifo[rx_fill] = rx_sr;
                     rx_fill++;
                     s.got = 1'b1;
                     led_q = ~led_q;
                  end
               end else begin
                  rx_bits++;
               end
            end else begin
               rx_ph = u8rf_pkg::RX_IDLE;
            end
         end
      end
      rx_prev = t.rx_line;

      if (t.clear) begin
         for (int i = 0; i < u8rf_pkg::FIFO_DEPTH; i++)
            rx_fifo[i] = 8'h00;
         rx_fill = 0;
      end

      s.head  = rx_fifo[0];
      s.count = CW'(rx_fill);
      s.led   = led_q;
      return s;
   endfunction

   task automatic check_field(input string what, input logic [7:0] want, input logic [7:0] got);
      if (got !== want) begin
         mismatches++;
         if (mismatches <= 40)
            $display("%0t tb: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
      end
   endtask

   // Checker and line model, both sampled on the rising edge.
   always @(posedge clock) begin : monitor
      tick_type   cur;
      status_type want;
      if (reset) begin
         tx_cfg  = u8rf_pkg::TX_BIT_TICKS_RESET;
         rx_cfg  = u8rf_pkg::RX_BIT_TICKS_RESET;
         tx_on   = 1'b0;
         tx_slot = '0;
         tx_byte = 8'h00;
         tx_left = 0;
         rx_ph   = u8rf_pkg::RX_IDLE;
         rx_left = 0;
         rx_bits = '0;
         rx_sr   = 8'h00;
         rx_prev = 1'b1;
         for (int i = 0; i < u8rf_pkg::FIFO_DEPTH; i++)
            rx_fifo[i] = 8'h00;
         rx_fill = 0;
         led_q   = 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (status_due.size() == 0) begin
               mismatches++;
               if (mismatches <= 40)
                  $display("%0t tb: response with no request pending, expected none, actual %0h",
                           $time, {rsp_tx_line, rsp_tx_busy, rsp_head_byte, rsp_fifo_count});
            end else begin
               want = status_due.pop_front();
               check_field("tx_line", 8'(want.line), 8'(rsp_tx_line));
               check_field("tx_busy", 8'(want.busy), 8'(rsp_tx_busy));
               check_field("head_byte", want.head, rsp_head_byte);
               check_field("fifo_count", 8'(want.count), 8'(rsp_fifo_count));
               check_field("byte_received", 8'(want.got), 8'(rsp_byte_received));
               check_field("activity_led", 8'(want.led), 8'(rsp_activity_led));
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               u8rf_pkg::CSR_TX_BIT_TICKS: tx_cfg = csr_wdata;
               u8rf_pkg::CSR_RX_BIT_TICKS: rx_cfg = csr_wdata;
               default: ;
            endcase
         end
         if (req_push && !req_full) begin
            cur = '{req_rx_line, req_tx_start, req_tx_data, req_pop_req, req_clear};
            status_due.push_back(uart_tick(cur));
         end
      end
   end

   // response side: pop with random stall bursts
   always @(posedge clock) begin
      if (pop_hold > 0) begin
         rsp_pop  <= 1'b0;
         pop_hold = pop_hold - 1;
      end else if (gaps_on && $urandom_range(0, 15) == 0) begin
         rsp_pop  <= 1'b0;
         pop_hold = $urandom_range(0, 8);
      end else begin
         rsp_pop <= 1'b1;
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles == CYCLE_LIMIT) begin
         $display("tb: FAIL");
         $finish;
      end
   end

   // Send one tick request; returns at the edge that accepts it, push left high.
   task automatic send_tick(input tick_type t);
      if (gaps_on && $urandom_range(0, 15) == 0) begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      req_push     <= 1'b1;
      req_rx_line  <= t.rx_line;
      req_tx_start <= t.tx_start;
      req_tx_data  <= t.tx_data;
      req_pop_req  <= t.pop_req;
      req_clear    <= t.clear;
      do @(posedge clock); while (req_full);
   endtask

   task automatic line_tick(input logic rx, input logic start, input logic [7:0] data,
                            input logic pop, input logic clr);
      send_tick('{rx, start, data, pop, clr});
   endtask

   task automatic queue_frame(input logic [7:0] data, input int unsigned stop_extra);
      int unsigned p;
      p = rx_rate();
      repeat (p) rx_levels.push_back(1'b0);
      for (int b = 0; b < 8; b++)
         repeat (p) rx_levels.push_back(data[b]);
      repeat (p + stop_extra) rx_levels.push_back(1'b1);
   endtask

   // Clock one clean frame in at the receive rate, optionally popping on the
   // start edge or clearing on the tick the byte lands.
   task automatic send_frame(input logic [7:0] data, input logic pop_at_edge,
                             input logic clear_at_store);
      int unsigned n, store_at, p;
      tick_type    t;
      p        = rx_rate();
      store_at = p / 2 + p + 7 * p;
      n        = 0;
      queue_frame(data, 0);
      while (rx_levels.size() != 0) begin
         t         = '0;
         t.rx_line = rx_levels.pop_front();
         t.pop_req = pop_at_edge && n == 0;
         t.clear   = clear_at_store && n == store_at;
         send_tick(t);
         n++;
      end
   endtask

   task automatic run_random(input int unsigned n, input int unsigned pop_pct,
                             input int unsigned clear_pct, input int unsigned start_pct);
      tick_type    t;
      int unsigned p, pick, cut;
      repeat (n) begin
         if (rx_levels.size() == 0) begin
            p    = rx_rate();
            pick = $urandom_range(0, 99);
            if (pick < 80) begin
               queue_frame(8'($urandom_range(0, 255)), $urandom_range(0, p));
            end else if (pick < 90) begin
               repeat ($urandom_range(1, 3 * p))
                  rx_levels.push_back(1'($urandom_range(0, 1)));
            end else begin
               // cut a frame short somewhere in its start or data bits
               queue_frame(8'($urandom_range(0, 255)), 0);
               cut = $urandom_range(1, 9 * p);
               while (rx_levels.size() > cut)
                  void'(rx_levels.pop_back());
            end
         end
         t.rx_line  = rx_levels.pop_front();
         t.tx_start = $urandom_range(0, 99) < start_pct;
         t.tx_data  = 8'($urandom_range(0, 255));
         t.pop_req  = $urandom_range(0, 99) < pop_pct;
         t.clear    = $urandom_range(0, 99) < clear_pct;
         send_tick(t);
      end
   endtask

   // Idle the line until both directions are quiet, then drain responses.
   // The model may lag the accept edge by one tick here; that costs at most
   // one extra idle tick.
   task automatic settle_line();
      rx_levels.delete();
      do line_tick(1'b1, 1'b0, 8'h00, 1'b0, 1'b0);
      while (tx_on || rx_ph != u8rf_pkg::RX_IDLE);
      req_push <= 1'b0;
      do @(posedge clock); while (status_due.size() != 0);
   endtask

   task automatic write_rates(input logic [15:0] tx, input logic [15:0] rx);
      csr_valid <= 1'b1;
      csr_index <= u8rf_pkg::CSR_TX_BIT_TICKS;
      csr_wdata <= tx;
      do @(posedge clock); while (!csr_ready);
      csr_index <= u8rf_pkg::CSR_RX_BIT_TICKS;
      csr_wdata <= rx;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // reset rates: one byte each way at the power-up bit times
   task automatic test_reset_rates();
      line_tick(1'b1, 1'b1, 8'hA5, 1'b0, 1'b0);
      send_frame(8'h3C, 1'b1, 1'b0);
      settle_line();
   endtask

   task automatic test_directed();
      write_rates(16'd1, 16'd2);
      send_frame(8'h00, 1'b0, 1'b0);
      line_tick(1'b1, 1'b1, 8'hFF, 1'b0, 1'b0);
      line_tick(1'b1, 1'b1, 8'h00, 1'b0, 1'b0);
      send_frame(8'hFF, 1'b0, 1'b1);
      send_frame(8'h81, 1'b0, 1'b0);
      line_tick(1'b1, 1'b0, 8'h00, 1'b1, 1'b0);
      line_tick(1'b1, 1'b0, 8'h00, 1'b1, 1'b0);
      line_tick(1'b1, 1'b1, 8'h00, 1'b0, 1'b1);
      settle_line();
   endtask

   // fill the FIFO, overrun it, then pop on the start edge of a full FIFO
   task automatic test_fifo_full();
      write_rates(16'd0, 16'd2);
      while (rx_fill < u8rf_pkg::FIFO_DEPTH)
         send_frame(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      settle_line();
      write_rates(16'd0, 16'd3);
      send_frame(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      settle_line();
      send_frame(8'($urandom_range(0, 255)), 1'b1, 1'b0);
      // keep the FIFO full while random traffic runs
      run_random(30, 0, 0, 20);
      settle_line();
   endtask

   task automatic test_random_rates();
      logic [15:0] tx_set [5] = '{16'd2, 16'd1, 16'd5, 16'd0, 16'd3};
      logic [15:0] rx_set [5] = '{16'd2, 16'd0, 16'd7, 16'd1, 16'd4};
      for (int k = 0; k < 5; k++) begin
         write_rates(tx_set[k], rx_set[k]);
         run_random(40, $urandom_range(3, 40), 2, 25);
         settle_line();
      end
   endtask

   // slowest rates with a full FIFO: the start edge is dropped for the long wait
   task automatic test_slow_rates();
      gaps_on = 1'b0;
      write_rates(16'd1, 16'd2);
      while (rx_fill < u8rf_pkg::FIFO_DEPTH)
         send_frame(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      settle_line();
      write_rates(16'hFFFF, 16'hFFFF);
      line_tick(1'b0, 1'b1, 8'($urandom_range(0, 255)), 1'b0, 1'b0);
      repeat (40)
         line_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                   8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0, 1'b0);
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_reset_rates();
      test_directed();
      test_random_rates();
      test_fifo_full();
      test_slow_rates();
      req_push <= 1'b0;
      do @(posedge clock); while (status_due.size() != 0);
      repeat (8) @(posedge clock);
      if (mismatches == 0)
         $display("tb: PASS");
      else
         $display("tb: FAIL");
      $finish;
   end

endmodule

`default_nettype wire
